// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the mouse controller rtl
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpic_pkg.sv =====
// ------------------------------------------------------------------------
// mpic_pkg
// request codes, bundles and reset constants of the mouse controller
// ------------------------------------------------------------------------
package mpic_pkg;

    localparam int MPIC_COORD_BITS = 16;
    localparam int MPIC_BOUND_MAX  = 1023;

    localparam logic [3:0] REQ_MOVE     = 4'd0;
    localparam logic [3:0] REQ_BUTTON   = 4'd1;
    localparam logic [3:0] REQ_VBLANK   = 4'd2;
    localparam logic [3:0] REQ_INIT     = 4'd3;
    localparam logic [3:0] REQ_SETMODE  = 4'd4;
    localparam logic [3:0] REQ_SERVE    = 4'd5;
    localparam logic [3:0] REQ_READ     = 4'd6;
    localparam logic [3:0] REQ_CLEAR    = 4'd7;
    localparam logic [3:0] REQ_POSITION = 4'd8;
    localparam logic [3:0] REQ_CLAMP    = 4'd9;
    localparam logic [3:0] REQ_HOME     = 4'd10;

    // mode bits
    localparam int MODE_ON      = 0;
    localparam int MODE_MOVE    = 1;
    localparam int MODE_BUTTON  = 2;
    localparam int MODE_VBLANK  = 3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic               button_pressed;
        logic               in_vblank;
        logic [3:0]         mode_value;
        logic               clamp_axis;
        logic signed [15:0] first_word;
        logic signed [15:0] second_word;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         status_byte;
        logic               button_now;
        logic [3:0]         mode_out;
        logic               irq_active;
        logic               irq_pulse;
    } res_t;

endpackage

// ===== rtl/mpic_core.sv =====
// ------------------------------------------------------------------------
// mpic_core
// controller state and the combinational update for one request
// ------------------------------------------------------------------------
module mpic_core #(
    parameter int COORD_BITS = mpic_pkg::MPIC_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  mpic_pkg::cmd_t cmd,
    output mpic_pkg::res_t res
);
    import mpic_pkg::*;

    localparam logic signed [COORD_BITS-1:0] BOUND_HI = COORD_BITS'(MPIC_BOUND_MAX);

    logic signed [COORD_BITS-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [COORD_BITS-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [COORD_BITS-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [2:0] btn_reg, btn_next;       // current, previous, changed
    logic       moved_reg, moved_next;
    logic [3:0] mode_reg, mode_next;
    logic [2:0] pend_reg, pend_next;     // move, button, vblank
    logic       irq_reg, irq_next;
    logic       vbl_reg, vbl_next;

    logic signed [COORD_BITS-1:0] dx_c, dy_c, w1_c, w2_c;
    logic [7:0] status;
    logic       pulse;

    function automatic logic signed [COORD_BITS-1:0] bound(
        input logic signed [COORD_BITS-1:0] v,
        input logic signed [COORD_BITS-1:0] lo,
        input logic signed [COORD_BITS-1:0] hi
    );
        logic signed [COORD_BITS-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    assign dx_c = cmd.delta_x[COORD_BITS-1:0];
    assign dy_c = cmd.delta_y[COORD_BITS-1:0];
    assign w1_c = cmd.first_word[COORD_BITS-1:0];
    assign w2_c = cmd.second_word[COORD_BITS-1:0];

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        btn_next   = btn_reg;
        moved_next = moved_reg;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        irq_next   = irq_reg;
        vbl_next   = vbl_reg;
        status     = 8'h00;
        pulse      = 1'b0;
        case (cmd.req_type)
            REQ_MOVE:
            begin
                if ((cmd.delta_x != 16'sd0) || (cmd.delta_y != 16'sd0))
                begin
                    pos_x_next = bound(pos_x_reg + dx_c, min_x_reg, max_x_reg);
                    pos_y_next = bound(pos_y_reg + dy_c, min_y_reg, max_y_reg);
                    moved_next = 1'b1;
                end
            end
            REQ_BUTTON:
            begin
                if (cmd.button_pressed != btn_reg[0])
                    btn_next = {1'b1, btn_reg[0], cmd.button_pressed};
            end
            REQ_VBLANK:
            begin
                if (cmd.in_vblank && !vbl_reg)
                begin
                    if (mode_reg[MODE_VBLANK])
                        pend_next[2] = 1'b1;
                    if (mode_reg[MODE_MOVE] && moved_reg)
                        pend_next[0] = 1'b1;
                    if (mode_reg[MODE_BUTTON] && btn_reg[2])
                    begin
                        pend_next[1] = 1'b1;
                        btn_next[2]  = 1'b0;
                    end
                    if (mode_reg[MODE_ON] && (pend_next != 3'b000))
                    begin
                        irq_next = 1'b1;
                        pulse    = 1'b1;
                    end
                end
                vbl_next = cmd.in_vblank;
            end
            REQ_INIT:
            begin
                min_x_next  = '0;
                max_x_next  = BOUND_HI;
                min_y_next  = '0;
                max_y_next  = BOUND_HI;
                pos_x_next  = '0;
                pos_y_next  = '0;
                moved_next  = 1'b0;
                btn_next[2] = 1'b0;
                mode_next   = 4'h0;
            end
            REQ_SETMODE:
            begin
                mode_next = cmd.mode_value;
                if (!cmd.mode_value[MODE_ON])
                begin
                    pend_next = 3'b000;
                    irq_next  = 1'b0;
                end
            end
            REQ_SERVE:
            begin
                status    = {4'h0, pend_reg, 1'b0};
                pend_next = 3'b000;
                irq_next  = 1'b0;
            end
            REQ_READ:
            begin
                status     = {btn_reg[0], btn_reg[1], moved_reg, 1'b0, pend_reg, 1'b0};
                moved_next = 1'b0;
                btn_next   = {btn_reg[2], btn_reg[0], btn_reg[0]};
            end
            REQ_CLEAR:
            begin
                pos_x_next = '0;
                pos_y_next = '0;
                moved_next = 1'b0;
            end
            REQ_POSITION:
            begin
                pos_x_next = bound(w1_c, min_x_reg, max_x_reg);
                pos_y_next = bound(w2_c, min_y_reg, max_y_reg);
            end
            REQ_CLAMP:
            begin
                if (!cmd.clamp_axis)
                begin
                    min_x_next = w1_c;
                    max_x_next = w2_c;
                    pos_x_next = bound(pos_x_reg, w1_c, w2_c);
                end
                else
                begin
                    min_y_next = w1_c;
                    max_y_next = w2_c;
                    pos_y_next = bound(pos_y_reg, w1_c, w2_c);
                end
            end
            REQ_HOME:
            begin
                pos_x_next = min_x_reg;
                pos_y_next = min_y_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            min_x_reg <= '0;
            max_x_reg <= BOUND_HI;
            min_y_reg <= '0;
            max_y_reg <= BOUND_HI;
            btn_reg   <= 3'b000;
            moved_reg <= 1'b0;
            mode_reg  <= 4'h0;
            pend_reg  <= 3'b000;
            irq_reg   <= 1'b0;
            vbl_reg   <= 1'b0;
        end
        else if (en)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            btn_reg   <= btn_next;
            moved_reg <= moved_next;
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            irq_reg   <= irq_next;
            vbl_reg   <= vbl_next;
        end
    end

    // coordinates shown sign-extended to 16 bits
    always_comb
    begin
        res.pos_x       = 16'(pos_x_next);
        res.pos_y       = 16'(pos_y_next);
        res.status_byte = status;
        res.button_now  = btn_next[0];
        res.mode_out    = mode_next;
        res.irq_active  = irq_next;
        res.irq_pulse   = pulse;
    end

endmodule

// ===== rtl/mouse_position_interrupt_controller.sv =====
// ------------------------------------------------------------------------
// mouse_position_interrupt_controller
// mouse position tracker with clamp bounds, button flags and vblank irq
// ------------------------------------------------------------------------
//
//  channel | direction | carries
//  --------+-----------+-----------------------------------------------
//  s_*     | in        | one request: command in tuser, operands in tdata
//  m_*     | out       | one result per request: position, status, irq
//
//  one request per cycle sustained while m_tready is high; a result is
//  presented on m_* once its request has passed through both registers
//  (input register, then result register)
//  the request register feeds the state update directly, so each request
//  sees the state left by the one before it with no bubbles
//  rst_n clears the valid flags and returns the state to its reset values
//  a stalled result holds the result register; the request register still
//  fills, and s_tready drops only when both are occupied
//
module mouse_position_interrupt_controller #(
    parameter int COORD_BITS = mpic_pkg::MPIC_COORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // delta_x[15:0], delta_y[31:16], button_pressed[32], in_vblank[33],
    // mode_value[37:34], clamp_axis[38], first_word[54:39],
    // second_word[70:55], zero[71]
    input  logic [71:0] s_tdata,
    // req_type[3:0]
    input  logic [3:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x[15:0], pos_y[31:16], status_byte[39:32], button_now[40],
    // mode_out[44:41], irq_active[45], irq_pulse[46], zero[47]
    output logic [47:0] m_tdata
);
    import mpic_pkg::*;

    `include "assert_macros.svh"

    logic in_valid_reg;
    cmd_t cmd_reg;
    logic out_valid_reg;
    res_t res_reg;
    res_t res_now;
    logic advance;      // request register moves into the result register

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd_reg.req_type       <= s_tuser;
            cmd_reg.delta_x        <= s_tdata[15:0];
            cmd_reg.delta_y        <= s_tdata[31:16];
            cmd_reg.button_pressed <= s_tdata[32];
            cmd_reg.in_vblank      <= s_tdata[33];
            cmd_reg.mode_value     <= s_tdata[37:34];
            cmd_reg.clamp_axis     <= s_tdata[38];
            cmd_reg.first_word     <= s_tdata[54:39];
            cmd_reg.second_word    <= s_tdata[70:55];
        end
    end

    // state and update logic, committed when the request moves on
    mpic_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cmd   (cmd_reg),
        .res   (res_now)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_now;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.irq_pulse, res_reg.irq_active, res_reg.mode_out,
                       res_reg.button_now, res_reg.status_byte, res_reg.pos_y,
                       res_reg.pos_x};

    // a fired interrupt always leaves the irq level raised
    `ASSERT_IMP(a_pulse_sets_irq, clk, rst_n, m_tvalid && res_reg.irq_pulse,
                res_reg.irq_active, "irq pulse without irq level")
    // an empty request register never refuses a request
    `ASSERT_IMP(a_ready_when_empty, clk, rst_n, !in_valid_reg, s_tready,
                "request refused while request register empty")
    // a moved request always leaves a result behind it
    `ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg,
                "result register empty after a request moved on")

endmodule
